[design/ssdp_pkg.sv]
// ----------------------------------------------------------------------------
// ssdp_pkg
// Shared types, field widths and command codes of the store-set predictor.
// ----------------------------------------------------------------------------
package ssdp_pkg;

	localparam int CMD_BITS       = 3;
	localparam int TAG_FIELD_BITS = 8;
	localparam int PC_INDEX_BITS  = 10;
	localparam int SET_ID_BITS    = 7;
	localparam int SET_ID_RANGE   = 2 ** SET_ID_BITS;

	localparam int SSIT_ENTRIES_DEF = 1024;
	localparam int LFMT_ENTRIES_DEF = 128;
	localparam int TAG_BITS_DEF     = 8;

	localparam logic [CMD_BITS-1:0] CMD_INSERT     = CMD_BITS'(0);
	localparam logic [CMD_BITS-1:0] CMD_REMOVE     = CMD_BITS'(1);
	localparam logic [CMD_BITS-1:0] CMD_VIOLATION  = CMD_BITS'(2);
	localparam logic [CMD_BITS-1:0] CMD_RESET_LAST = CMD_BITS'(3);
	localparam logic [CMD_BITS-1:0] CMD_CLEAR_ALL  = CMD_BITS'(4);

	typedef struct packed {
		logic [CMD_BITS-1:0]       command;
		logic [TAG_FIELD_BITS-1:0] inst_tag;
		logic [PC_INDEX_BITS-1:0]  pc_index;
		logic                      is_store;
		logic                      inst_set_valid;
		logic [SET_ID_BITS-1:0]    inst_set_id;
		logic [PC_INDEX_BITS-1:0]  young_index;
		logic                      young_set_valid;
		logic [SET_ID_BITS-1:0]    young_set_id;
	} req_t;

	typedef struct packed {
		logic                      set_valid;
		logic [SET_ID_BITS-1:0]    set_id;
		logic                      dep_valid;
		logic [TAG_FIELD_BITS-1:0] dep_tag;
		logic                      last_table_empty;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic red;
		logic ins_ssit_rd;
		logic ins_lfmt_rd;
		logic ins_upd;
		logic rem_rd;
		logic rem_upd;
		logic vio_old;
		logic vio_young;
		logic clr_start;
		logic clr_all;
		logic clr_step;
		logic rsp_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_BITS-1:0] op;
		logic                clr_last;
		logic                rsp_full;
	} dp_status_t;

endpackage

[design/ssdp_ctrl.sv]
// ----------------------------------------------------------------------------
// ssdp_ctrl
// Sequencer of the store-set predictor: steps one command through reads,
// writes, clearing sweeps and the result register.
// ----------------------------------------------------------------------------
module ssdp_ctrl import ssdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RED,
		S_INS_SSIT,
		S_INS_LFMT,
		S_INS_UPD,
		S_REM_RD,
		S_REM_UPD,
		S_VIO_OLD,
		S_VIO_YOUNG,
		S_CLR,
		S_OUT
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_RED;
				end
			end
			S_RED: begin
				cmd.red = 1'b1;
				case (status.op)
					CMD_INSERT:    state_d = S_INS_SSIT;
					CMD_REMOVE:    state_d = S_REM_RD;
					CMD_VIOLATION: state_d = S_VIO_OLD;
					CMD_RESET_LAST: begin
						cmd.clr_start = 1'b1;
						state_d       = S_CLR;
					end
					CMD_CLEAR_ALL: begin
						cmd.clr_start = 1'b1;
						cmd.clr_all   = 1'b1;
						state_d       = S_CLR;
					end
					default:       state_d = S_OUT;
				endcase
			end
			S_INS_SSIT: begin
				cmd.ins_ssit_rd = 1'b1;
				state_d         = S_INS_LFMT;
			end
			S_INS_LFMT: begin
				cmd.ins_lfmt_rd = 1'b1;
				state_d         = S_INS_UPD;
			end
			S_INS_UPD: begin
				cmd.ins_upd = 1'b1;
				state_d     = S_OUT;
			end
			S_REM_RD: begin
				cmd.rem_rd = 1'b1;
				state_d    = S_REM_UPD;
			end
			S_REM_UPD: begin
				cmd.rem_upd = 1'b1;
				state_d     = S_OUT;
			end
			S_VIO_OLD: begin
				cmd.vio_old = 1'b1;
				state_d     = S_VIO_YOUNG;
			end
			S_VIO_YOUNG: begin
				cmd.vio_young = 1'b1;
				state_d       = S_OUT;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// hold until the result register has room
				if (!status.rsp_full) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/ssdp_dp.sv]
// ----------------------------------------------------------------------------
// ssdp_dp
// Datapath of the store-set predictor: set-ID table, last-fetched table,
// set counter, clearing sweep and the result register.
// ----------------------------------------------------------------------------
module ssdp_dp import ssdp_pkg::*; #(
	parameter int SSIT_ENTRIES = SSIT_ENTRIES_DEF,
	parameter int LFMT_ENTRIES = LFMT_ENTRIES_DEF,
	parameter int TAG_BITS     = TAG_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  logic       rsp_stall,
	output logic       rsp_valid,
	output rsp_t       rsp
);

	localparam int SW   = $clog2(SSIT_ENTRIES);
	localparam int IDW  = $clog2(LFMT_ENTRIES);
	localparam int MAXE = (SSIT_ENTRIES > LFMT_ENTRIES) ? SSIT_ENTRIES : LFMT_ENTRIES;
	localparam int CW   = $clog2(MAXE);
	localparam int CNTW = $clog2(LFMT_ENTRIES + 1);

	typedef struct packed {
		logic           valid;
		logic [IDW-1:0] id;
	} ssit_ent_t;

	typedef struct packed {
		logic                valid;
		logic [TAG_BITS-1:0] tag;
	} lfmt_ent_t;

	ssit_ent_t ssit_mem [SSIT_ENTRIES];
	lfmt_ent_t lfmt_mem [LFMT_ENTRIES];

	req_t            req_q;
	logic            order_loads_q;
	ssit_ent_t       ssit_rd_q;
	lfmt_ent_t       lfmt_rd_q;
	logic [IDW-1:0]  set_cnt_q;
	logic [CNTW-1:0] valid_cnt_q;
	logic [CW-1:0]   clr_idx_q;
	logic            clr_all_q;
	rsp_t            res_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	// set IDs reduced to the last-fetched table range
	logic [IDW-1:0] id_tbl [SET_ID_RANGE];
	for (genvar g = 0; g < SET_ID_RANGE; g++) begin : g_id_tbl
		assign id_tbl[g] = IDW'(g % LFMT_ENTRIES);
	end

	// ---- set-ID table index reduction ----
	logic [SW-1:0] pidx, yidx;

	if (SSIT_ENTRIES >= (2 ** PC_INDEX_BITS)) begin : g_idx_wide
		assign pidx = SW'(req_q.pc_index);
		assign yidx = SW'(req_q.young_index);
	end else if ((SSIT_ENTRIES & (SSIT_ENTRIES - 1)) == 0) begin : g_idx_pow2
		assign pidx = req_q.pc_index[SW-1:0];
		assign yidx = req_q.young_index[SW-1:0];
	end else begin : g_idx_recip
		// quotient by reciprocal, registered, then remainder with one correction
		localparam int RS = PC_INDEX_BITS + SW;
		localparam longint unsigned RM =
			((64'd1 << RS) + longint'(SSIT_ENTRIES) - 64'd1) / longint'(SSIT_ENTRIES);
		localparam int MW = PC_INDEX_BITS + 2;
		localparam int PW = PC_INDEX_BITS + MW;
		localparam logic [PC_INDEX_BITS-1:0] DIV = PC_INDEX_BITS'(SSIT_ENTRIES);

		logic [PW-1:0]            pp, yp;
		logic [PC_INDEX_BITS-1:0] pq_q, yq_q;
		logic [PC_INDEX_BITS-1:0] pr, yr;

		assign pp = PW'(req_q.pc_index) * PW'(RM);
		assign yp = PW'(req_q.young_index) * PW'(RM);

		always_ff @(posedge clk) begin
			if (cmd.red) begin
				pq_q <= PC_INDEX_BITS'(pp >> RS);
				yq_q <= PC_INDEX_BITS'(yp >> RS);
			end
		end

		assign pr   = req_q.pc_index - PC_INDEX_BITS'(pq_q * DIV);
		assign yr   = req_q.young_index - PC_INDEX_BITS'(yq_q * DIV);
		assign pidx = SW'((pr >= DIV) ? (pr - DIV) : pr);
		assign yidx = SW'((yr >= DIV) ? (yr - DIV) : yr);
	end

	// ---- violation: merged set ID ----
	logic                   both_new;
	logic [SET_ID_BITS-1:0] raw_id;
	logic [IDW-1:0]         new_id;

	assign both_new = !req_q.inst_set_valid && !req_q.young_set_valid;

	always_comb begin
		if (!req_q.inst_set_valid) begin
			raw_id = req_q.young_set_id;
		end else if (!req_q.young_set_valid) begin
			raw_id = req_q.inst_set_id;
		end else if (req_q.inst_set_id < req_q.young_set_id) begin
			raw_id = req_q.inst_set_id;
		end else begin
			raw_id = req_q.young_set_id;
		end
	end

	assign new_id = both_new ? set_cnt_q : id_tbl[raw_id];

	// ---- insert and remove decisions ----
	logic                ins_write;
	logic                rem_hit;
	logic [TAG_BITS-1:0] tag_m;
	logic [IDW-1:0]      rem_id;

	assign tag_m     = TAG_BITS'(req_q.inst_tag);
	assign rem_id    = id_tbl[req_q.inst_set_id];
	assign ins_write = ssit_rd_q.valid && (req_q.is_store || order_loads_q);
	assign rem_hit   = req_q.inst_set_valid && lfmt_rd_q.valid && (lfmt_rd_q.tag == tag_m);

	// ---- clearing sweep ----
	logic clr_ssit_wr, clr_lfmt_wr;

	assign clr_ssit_wr = cmd.clr_step && clr_all_q && (32'(clr_idx_q) < SSIT_ENTRIES);
	assign clr_lfmt_wr = cmd.clr_step && (32'(clr_idx_q) < LFMT_ENTRIES);

	// ---- table write ports ----
	logic            ssit_we;
	logic [SW-1:0]   ssit_wa;
	ssit_ent_t       ssit_wd;
	logic            lfmt_we;
	logic [IDW-1:0]  lfmt_wa;
	lfmt_ent_t       lfmt_wd;
	logic [IDW-1:0]  lfmt_ra;

	always_comb begin
		ssit_we = 1'b0;
		ssit_wa = pidx;
		ssit_wd = '{valid: 1'b1, id: new_id};
		if (clr_ssit_wr) begin
			ssit_we = 1'b1;
			ssit_wa = clr_idx_q[SW-1:0];
			ssit_wd = '0;
		end else if (cmd.vio_old) begin
			ssit_we = 1'b1;
		end else if (cmd.vio_young) begin
			ssit_we = 1'b1;
			ssit_wa = yidx;
		end
	end

	always_comb begin
		lfmt_we = 1'b0;
		lfmt_wa = ssit_rd_q.id;
		lfmt_wd = '{valid: 1'b1, tag: tag_m};
		if (clr_lfmt_wr) begin
			lfmt_we = 1'b1;
			lfmt_wa = clr_idx_q[IDW-1:0];
			lfmt_wd = '0;
		end else if (cmd.ins_upd && ins_write) begin
			lfmt_we = 1'b1;
		end else if (cmd.rem_upd && rem_hit) begin
			lfmt_we = 1'b1;
			lfmt_wa = rem_id;
			lfmt_wd = '0;
		end
	end

	assign lfmt_ra = cmd.rem_rd ? rem_id : ssit_rd_q.id;

	always_ff @(posedge clk) begin
		if (ssit_we) begin
			ssit_mem[ssit_wa] <= ssit_wd;
		end
		if (cmd.ins_ssit_rd) begin
			ssit_rd_q <= ssit_mem[pidx];
		end
	end

	always_ff @(posedge clk) begin
		if (lfmt_we) begin
			lfmt_mem[lfmt_wa] <= lfmt_wd;
		end
		if (cmd.ins_lfmt_rd || cmd.rem_rd) begin
			lfmt_rd_q <= lfmt_mem[lfmt_ra];
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
			res_q <= '0;
		end else if (cmd.ins_upd) begin
			res_q.set_valid <= ssit_rd_q.valid;
			res_q.set_id    <= ssit_rd_q.valid ? SET_ID_BITS'(ssit_rd_q.id) : '0;
			res_q.dep_valid <= ssit_rd_q.valid && lfmt_rd_q.valid;
			res_q.dep_tag   <= (ssit_rd_q.valid && lfmt_rd_q.valid) ?
				TAG_FIELD_BITS'(lfmt_rd_q.tag) : '0;
		end
		if (cmd.rsp_load) begin
			rsp_q <= '{set_valid: res_q.set_valid, set_id: res_q.set_id,
				dep_valid: res_q.dep_valid, dep_tag: res_q.dep_tag,
				last_table_empty: (valid_cnt_q == '0)};
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_loads_q <= 1'b0;
			set_cnt_q     <= '0;
			valid_cnt_q   <= '0;
			clr_idx_q     <= '0;
			clr_all_q     <= 1'b1;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				order_loads_q <= cfg_wr_data;
			end
			if (cmd.vio_young && both_new) begin
				set_cnt_q <= (set_cnt_q == IDW'(LFMT_ENTRIES - 1)) ? '0 : set_cnt_q + IDW'(1);
			end
			if (cmd.clr_start) begin
				valid_cnt_q <= '0;
				clr_idx_q   <= '0;
				clr_all_q   <= cmd.clr_all;
			end else begin
				if (cmd.clr_step) begin
					clr_idx_q <= clr_idx_q + CW'(1);
				end
				if (cmd.ins_upd && ins_write && !lfmt_rd_q.valid) begin
					valid_cnt_q <= valid_cnt_q + CNTW'(1);
				end else if (cmd.rem_upd && rem_hit) begin
					valid_cnt_q <= valid_cnt_q - CNTW'(1);
				end
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign status.op       = req_q.command;
	assign status.clr_last = clr_all_q ? (32'(clr_idx_q) == MAXE - 1)
	                                   : (32'(clr_idx_q) == LFMT_ENTRIES - 1);
	assign status.rsp_full = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[design/store_set_dependence_predictor_top.sv]
// ----------------------------------------------------------------------------
// store_set_dependence_predictor_top: store-set memory dependence predictor
// Each command first passes index reduction; insert then does the dependent
// set-ID then last-fetched table reads and the update, violation writes the
// old then young set-ID entry, remove reads and updates; one request at a time.
// Reset: sweeps max(SSIT_ENTRIES, LFMT_ENTRIES) rows, req_stall high meanwhile.
// ----------------------------------------------------------------------------
module store_set_dependence_predictor_top import ssdp_pkg::*; #(
	parameter int SSIT_ENTRIES = SSIT_ENTRIES_DEF,
	parameter int LFMT_ENTRIES = LFMT_ENTRIES_DEF,
	parameter int TAG_BITS     = TAG_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ssdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.status    (status)
	);

	ssdp_dp #(
		.SSIT_ENTRIES (SSIT_ENTRIES),
		.LFMT_ENTRIES (LFMT_ENTRIES),
		.TAG_BITS     (TAG_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp)
	);

endmodule

[tb/ssdp_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// ssdp_scoreboard_pkg
// Shadow set-ID and last-fetched tables for the store-set predictor. Each
// accepted request is applied to the shadow state, and the response it should
// produce is queued. Response beats are then checked in order, field by field.
// ----------------------------------------------------------------------------
package ssdp_scoreboard_pkg;
	import ssdp_pkg::*;

	class ssdp_scoreboard;
		bit                        order_loads;
		bit                        ssit_vld [SSIT_ENTRIES_DEF];
		bit [SET_ID_BITS-1:0]      ssit_set [SSIT_ENTRIES_DEF];
		bit                        lfmt_vld [LFMT_ENTRIES_DEF];
		bit [TAG_FIELD_BITS-1:0]   lfmt_owner [LFMT_ENTRIES_DEF];
		bit [SET_ID_BITS-1:0]      fresh_set;
		rsp_t                      pending_answers[$];
		int                        failures;

		function void empty_last_fetched();
			foreach (lfmt_vld[i]) begin
				lfmt_vld[i] = 1'b0;
				lfmt_owner[i] = '0;
			end
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		function rsp_t note_request(req_t r);
			rsp_t answer;
			bit [SET_ID_BITS-1:0] sid;
			answer = '0;
			case (r.command)
			CMD_INSERT: begin
				if (ssit_vld[r.pc_index]) begin
					sid = ssit_set[r.pc_index];
					answer.set_valid = 1'b1;
					answer.set_id = sid;
					if (lfmt_vld[sid]) begin
						answer.dep_valid = 1'b1;
						answer.dep_tag = lfmt_owner[sid];
					end
					if (r.is_store || order_loads) begin
						lfmt_vld[sid] = 1'b1;
						lfmt_owner[sid] = r.inst_tag;
					end
				end
			end
			CMD_REMOVE: begin
				// free only if this instruction is still the last member
				if (r.inst_set_valid && lfmt_vld[r.inst_set_id]
						&& lfmt_owner[r.inst_set_id] == r.inst_tag) begin
					lfmt_vld[r.inst_set_id] = 1'b0;
					lfmt_owner[r.inst_set_id] = '0;
				end
			end
			CMD_VIOLATION: begin
				if (!r.inst_set_valid && !r.young_set_valid) begin
					sid = fresh_set;
					// wraps at the set-ID field width
					fresh_set = fresh_set + 1'b1;
				end else if (!r.inst_set_valid) begin
					sid = r.young_set_id;
				end else if (!r.young_set_valid) begin
					sid = r.inst_set_id;
				end else begin
					sid = (r.inst_set_id < r.young_set_id) ? r.inst_set_id : r.young_set_id;
				end
				ssit_vld[r.pc_index] = 1'b1;
				ssit_set[r.pc_index] = sid;
				ssit_vld[r.young_index] = 1'b1;
				ssit_set[r.young_index] = sid;
			end
			CMD_RESET_LAST: begin
				empty_last_fetched();
			end
			CMD_CLEAR_ALL: begin
				foreach (ssit_vld[i]) begin
					ssit_vld[i] = 1'b0;
					ssit_set[i] = '0;
				end
				empty_last_fetched();
			end
			default: begin
			end
			endcase
			answer.last_table_empty = 1'b1;
			foreach (lfmt_vld[i]) begin
				if (lfmt_vld[i])
					answer.last_table_empty = 1'b0;
			end
			pending_answers.push_back(answer);
			return answer;
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			int bad;
			bad = 0;
			if (pending_answers.size() == 0) begin
				$error("response beat with nothing outstanding: %h", got);
				failures++;
				return;
			end
			want = pending_answers.pop_front();
			if (got.set_valid !== want.set_valid) begin
				$error("set_valid: expected %0d, actual %0d", want.set_valid, got.set_valid);
				bad++;
			end
			if (got.set_id !== want.set_id) begin
				$error("set_id: expected %0d, actual %0d", want.set_id, got.set_id);
				bad++;
			end
			if (got.dep_valid !== want.dep_valid) begin
				$error("dep_valid: expected %0d, actual %0d", want.dep_valid, got.dep_valid);
				bad++;
			end
			if (got.dep_tag !== want.dep_tag) begin
				$error("dep_tag: expected %0d, actual %0d", want.dep_tag, got.dep_tag);
				bad++;
			end
			if (got.last_table_empty !== want.last_table_empty) begin
				$error("last_table_empty: expected %0d, actual %0d",
					want.last_table_empty, got.last_table_empty);
				bad++;
			end
			if (bad != 0)
				failures++;
		endfunction
	endclass

endpackage

[tb/store_set_dependence_predictor_top_tb.sv]
// ----------------------------------------------------------------------------
// store_set_dependence_predictor_top_tb
// Drives insert, remove, violation and table-clear requests into the
// predictor. This covers directed corner cases first, then random
// instruction streams under three idling mixes and a long response hold-off.
// Every response beat is checked against the shadow tables.
// ----------------------------------------------------------------------------
module store_set_dependence_predictor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssdp_pkg::*;
	import ssdp_scoreboard_pkg::*;

	localparam int HOT_PCS      = 12;
	localparam int INFLIGHT_MAX = 32;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = CMD_CLEAR_ALL + 1'b1;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = '1;

	typedef struct packed {
		logic [TAG_FIELD_BITS-1:0] tag;
		logic [PC_INDEX_BITS-1:0]  pc;
		logic                      in_set;
		logic [SET_ID_BITS-1:0]    set_id;
	} inflight_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic long_hold = 1'b0;
	event hold_start;

	ssdp_scoreboard sb;
	logic [PC_INDEX_BITS-1:0]  hot_pc [HOT_PCS];
	logic [TAG_FIELD_BITS-1:0] next_tag = '0;
	inflight_t inflight_q[$];

	store_set_dependence_predictor_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("store_set_dependence_predictor_top regression: fail");
		$finish;
	end

	always @(negedge clk) begin
		rsp_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
	end

	// hold off the response side long enough to back the block up
	initial begin
		forever begin
			@(hold_start);
			@(posedge clk);
			long_hold = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			long_hold = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	function automatic req_t req_of(logic [CMD_BITS-1:0] cmd, logic [TAG_FIELD_BITS-1:0] tag,
			logic [PC_INDEX_BITS-1:0] pc, logic st, logic ov, logic [SET_ID_BITS-1:0] oid,
			logic [PC_INDEX_BITS-1:0] yi, logic yv, logic [SET_ID_BITS-1:0] yid);
		req_t r;
		r.command = cmd;
		r.inst_tag = tag;
		r.pc_index = pc;
		r.is_store = st;
		r.inst_set_valid = ov;
		r.inst_set_id = oid;
		r.young_index = yi;
		r.young_set_valid = yv;
		r.young_set_id = yid;
		return r;
	endfunction

	function automatic req_t random_fields();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	// called at a falling edge; returns at the falling edge after the accept
	task automatic push_request(input req_t r, output rsp_t answer);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		answer = sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_order_loads(input logic value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.order_loads = value;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(negedge clk);
	endtask

	task automatic run_directed();
		req_t seq[$];
		rsp_t answer;
		seq.push_back(req_of(CMD_INSERT, 8'h00, 10'd0, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_VIOLATION, 8'h00, 10'd0, 1'b0, 1'b0, 7'd0, 10'd1023, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_INSERT, 8'hFF, 10'd0, 1'b1, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_INSERT, 8'h01, 10'd1023, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		// same tag as the last member: dependence still reported
		seq.push_back(req_of(CMD_INSERT, 8'hFF, 10'd1023, 1'b1, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_REMOVE, 8'h07, 10'd0, 1'b0, 1'b1, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_REMOVE, 8'hFF, 10'd0, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_REMOVE, 8'hFF, 10'd0, 1'b0, 1'b1, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_VIOLATION, 8'h00, 10'd5, 1'b0, 1'b1, 7'd127, 10'd6, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_VIOLATION, 8'h00, 10'd7, 1'b0, 1'b0, 7'd0, 10'd8, 1'b1, 7'd127));
		seq.push_back(req_of(CMD_VIOLATION, 8'h00, 10'd5, 1'b0, 1'b1, 7'd3, 10'd9, 1'b1, 7'd127));
		seq.push_back(req_of(CMD_VIOLATION, 8'h00, 10'd10, 1'b0, 1'b1, 7'd127, 10'd11, 1'b1, 7'd3));
		seq.push_back(req_of(CMD_VIOLATION, 8'h00, 10'd12, 1'b0, 1'b0, 7'd0, 10'd12, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_INSERT, 8'h80, 10'd5, 1'b1, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_INSERT, 8'h81, 10'd9, 1'b1, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_SPARE_FIRST, '1, '1, 1'b1, 1'b1, '1, '1, 1'b1, '1));
		seq.push_back(req_of(CMD_SPARE_FIRST + 1'b1, '1, '1, 1'b1, 1'b1, '1, '1, 1'b1, '1));
		seq.push_back(req_of(CMD_SPARE_LAST, '1, '1, 1'b1, 1'b1, '1, '1, 1'b1, '1));
		seq.push_back(req_of(CMD_RESET_LAST, 8'h00, 10'd0, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_INSERT, 8'h55, 10'd9, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_CLEAR_ALL, 8'h00, 10'd0, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		// unused fields all ones on an insert that finds no set
		seq.push_back(req_of(CMD_INSERT, '1, 10'd5, 1'b1, 1'b1, '1, '1, 1'b1, '1));
		foreach (seq[i])
			push_request(seq[i], answer);
		drain();
		write_order_loads(1'b1);
		seq.delete();
		seq.push_back(req_of(CMD_VIOLATION, 8'h00, 10'd100, 1'b0, 1'b0, 7'd0, 10'd200, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_INSERT, 8'h0F, 10'd100, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_INSERT, 8'hF0, 10'd200, 1'b0, 1'b0, 7'd0, 10'd0, 1'b0, 7'd0));
		seq.push_back(req_of(CMD_REMOVE, 8'hF0, 10'd0, 1'b0, 1'b1, 7'd2, 10'd0, 1'b0, 7'd0));
		foreach (seq[i])
			push_request(seq[i], answer);
	endtask

	task automatic run_random(input int count);
		req_t r;
		rsp_t answer;
		inflight_t a;
		inflight_t b;
		int roll;
		int idx;
		repeat (count) begin
			r = random_fields();
			roll = $urandom_range(0, 99);
			if (roll < 42) begin
				r.command = CMD_INSERT;
				r.inst_tag = next_tag;
				next_tag = next_tag + 1'b1;
				if ($urandom_range(0, 4) != 0)
					r.pc_index = hot_pc[$urandom_range(0, HOT_PCS - 1)];
			end else if (roll < 60) begin
				r.command = CMD_REMOVE;
				if (inflight_q.size() != 0 && $urandom_range(0, 7) != 0) begin
					idx = $urandom_range(0, inflight_q.size() - 1);
					a = inflight_q[idx];
					inflight_q.delete(idx);
					r.inst_tag = a.tag;
					r.inst_set_valid = a.in_set;
					r.inst_set_id = a.set_id;
				end
			end else if (roll < 84) begin
				r.command = CMD_VIOLATION;
				if (inflight_q.size() >= 2 && $urandom_range(0, 3) != 0) begin
					a = inflight_q[$urandom_range(0, inflight_q.size() - 1)];
					b = inflight_q[$urandom_range(0, inflight_q.size() - 1)];
					r.pc_index = a.pc;
					r.inst_set_valid = a.in_set;
					r.inst_set_id = a.set_id;
					r.young_index = b.pc;
					r.young_set_valid = b.in_set;
					r.young_set_id = b.set_id;
				end else begin
					r.pc_index = hot_pc[$urandom_range(0, HOT_PCS - 1)];
					r.young_index = hot_pc[$urandom_range(0, HOT_PCS - 1)];
				end
			end else if (roll < 92) begin
				r.command = CMD_BITS'($urandom_range(CMD_INSERT, CMD_CLEAR_ALL));
			end else if (roll < 96) begin
				r.command = CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
			end else if (roll < 98) begin
				r.command = CMD_RESET_LAST;
			end else begin
				r.command = CMD_CLEAR_ALL;
			end
			push_request(r, answer);
			if (r.command == CMD_INSERT) begin
				a.tag = r.inst_tag;
				a.pc = r.pc_index;
				a.in_set = answer.set_valid;
				a.set_id = answer.set_id;
				inflight_q.push_back(a);
				if (inflight_q.size() > INFLIGHT_MAX)
					void'(inflight_q.pop_front());
			end
		end
	endtask

	initial begin
		req_t r;
		rsp_t answer;
		sb = new();
		foreach (hot_pc[i])
			hot_pc[i] = PC_INDEX_BITS'($urandom);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// let the post-reset table sweep finish
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		write_order_loads(1'b0);
		run_directed();

		drain();
		write_order_loads(1'b0);
		set_idling(29, 60);
		run_random(230);

		drain();
		write_order_loads(1'b1);
		set_idling(60, 29);
		run_random(230);

		drain();
		write_order_loads(1'b0);
		set_idling(0, 0);
		// allocate enough fresh sets to wrap the set counter
		repeat (130) begin
			r = random_fields();
			r.command = CMD_VIOLATION;
			r.inst_set_valid = 1'b0;
			r.young_set_valid = 1'b0;
			push_request(r, answer);
		end
		-> hold_start;
		run_random(120);

		drain();
		repeat (16) @(negedge clk);
		if (sb.failures == 0) begin
			$display("store_set_dependence_predictor_top regression: pass");
		end else begin
			$display("store_set_dependence_predictor_top regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
design/ssdp_pkg.sv
design/ssdp_ctrl.sv
design/ssdp_dp.sv
design/store_set_dependence_predictor_top.sv
tb/ssdp_scoreboard_pkg.sv
tb/store_set_dependence_predictor_top_tb.sv
